@@ design/hrd_pkg.sv @@
// shared constants, types and state encoding for the heartbeat rate detector
// no dependencies
package hrd_pkg;

    localparam int DEF_WINDOW      = 4;
    localparam int DEF_SAMPLE_BITS = 10;
    localparam int DEF_COUNT_BITS  = 16;

    localparam int THRESH_W = 10;
    localparam int PERIOD_W = 10;
    localparam int CFG_W    = 10;
    localparam int RATE_W   = 20;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd520;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd20;

    localparam logic [RATE_W-1:0] RATE_NUMERATOR = 20'd600000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } hrd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hrd_div_status_t;

endpackage

@@ design/heartbeat_rate_detector.sv @@
// heartbeat rate detector top level: moving window sum, threshold beat detect,
// shift-add interval multiply and serial rate division (hrd_divider, hrd_pkg)
// without a beat a sample passes through update and output; a beat adds the shift-add multiply,
// a check and the divide, skipped at a zero interval; a new sample is taken only after the last
// is through, and the output register frees the input while a result waits
// reset: sync active-low aresetn clears window, sum, counters, interval, rate and flags, not other data
module heartbeat_rate_detector #(
    parameter int WINDOW      = hrd_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = hrd_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = hrd_pkg::DEF_COUNT_BITS,
    localparam int IN_W   = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW),
    localparam int INT_W  = COUNT_BITS + hrd_pkg::PERIOD_W,
    localparam int OUT_W  = ((1 + SUM_W + INT_W + hrd_pkg::RATE_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [hrd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [hrd_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_W-1:0]                s_axis_tdata,   // sample
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_W-1:0]               m_axis_tdata    // beat, average_sum, interval_ms, rate_tenths
);
    import hrd_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LVL_W  = THRESH_W + $clog2(WINDOW);
    localparam int CMP_W  = (SUM_W > LVL_W) ? SUM_W : LVL_W;
    localparam int MSTEP_W = $clog2(PERIOD_W);
    localparam logic [SUM_W:0] SUM_MAX = (SUM_W + 1)'(WINDOW * ((1 << SAMPLE_BITS) - 1));

    hrd_state_t state_reg, state_next;

    logic [THRESH_W-1:0]    thresh_reg, thresh_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [SAMPLE_BITS-1:0] window_reg [WINDOW];
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   above_reg, above_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [INT_W-1:0]       interval_reg, interval_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                   beat_reg, beat_next;
    logic [COUNT_BITS-1:0]  mcand_reg, mcand_next;
    logic [PERIOD_W-1:0]    mbits_reg, mbits_next;
    logic [MSTEP_W-1:0]     mstep_reg, mstep_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg, m_data_next;

    logic [SUM_W-1:0]      sum_upd;
    logic [LVL_W-1:0]      level;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  hit;
    logic                  in_xfer;
    logic                  out_load;
    logic                  div_start;
    hrd_div_status_t       div_st;
    logic [RATE_W-1:0]     div_quot;

    hrd_divider #(
        .DIV_W (INT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (interval_reg),
        .status   (div_st),
        .quotient (div_quot)
    );

    assign sum_upd = sum_reg - SUM_W'(window_reg[slot_reg]) + SUM_W'(sample_reg);
    assign level   = LVL_W'(thresh_reg) * LVL_W'(WINDOW);
    assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + COUNT_BITS'(1);
    assign hit     = !above_reg && (CMP_W'(sum_upd) > CMP_W'(level));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_xfer) state_next = ST_UPDATE;
            ST_UPDATE: state_next = hit ? ST_MUL : ST_OUT;
            ST_MUL:    if (mstep_reg == '0) state_next = ST_CHECK;
            ST_CHECK:  state_next = (interval_reg != '0) ? ST_DIV : ST_OUT;
            ST_DIV:    if (div_st.done) state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = (state_reg == ST_IDLE);
        div_start     = (state_reg == ST_CHECK) && (interval_reg != '0);
        out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);
    end

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // datapath
    always_comb begin
        thresh_next   = thresh_reg;
        period_next   = period_reg;
        slot_next     = slot_reg;
        sum_next      = sum_reg;
        above_next    = above_reg;
        cnt_next      = cnt_reg;
        interval_next = interval_reg;
        rate_next     = rate_reg;
        sample_next   = sample_reg;
        beat_next     = beat_reg;
        mcand_next    = mcand_reg;
        mbits_next    = mbits_reg;
        mstep_next    = mstep_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_THRESHOLD: thresh_next = THRESH_W'(cfg_wdata);
                CFG_PERIOD:    period_next = PERIOD_W'(cfg_wdata);
                default:       ;
            endcase
        end

        if (in_xfer) begin
            sample_next = s_axis_tdata[SAMPLE_BITS-1:0];
        end

        case (state_reg)
            ST_UPDATE: begin
                sum_next  = sum_upd;
                slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                beat_next = hit;
                if (hit) begin
                    above_next    = 1'b1;
                    cnt_next      = '0;
                    mcand_next    = cnt_inc;
                    mbits_next    = period_reg;
                    mstep_next    = MSTEP_W'(PERIOD_W - 1);
                    interval_next = '0;
                end else begin
                    cnt_next = cnt_inc;
                    if (above_reg && (CMP_W'(sum_upd) < CMP_W'(level))) begin
                        above_next = 1'b0;
                    end
                end
            end
            ST_MUL: begin
                interval_next = {interval_reg[INT_W-2:0], 1'b0}
                              + (mbits_reg[PERIOD_W-1] ? INT_W'(mcand_reg) : '0);
                mbits_next    = {mbits_reg[PERIOD_W-2:0], 1'b0};
                mstep_next    = mstep_reg - 1'b1;
            end
            ST_DIV: begin
                if (div_st.done) rate_next = div_quot;
            end
            default: ;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({rate_reg, interval_reg, sum_reg, beat_reg});
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thresh_reg   <= THRESH_RESET;
            period_reg   <= PERIOD_RESET;
            for (int i = 0; i < WINDOW; i++) window_reg[i] <= '0;
            slot_reg     <= '0;
            sum_reg      <= '0;
            above_reg    <= 1'b0;
            cnt_reg      <= '0;
            interval_reg <= '0;
            rate_reg     <= '0;
            beat_reg     <= 1'b0;
            mstep_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            thresh_reg   <= thresh_next;
            period_reg   <= period_next;
            if (state_reg == ST_UPDATE) window_reg[slot_reg] <= sample_reg;
            slot_reg     <= slot_next;
            sum_reg      <= sum_next;
            above_reg    <= above_next;
            cnt_reg      <= cnt_next;
            interval_reg <= interval_next;
            rate_reg     <= rate_next;
            beat_reg     <= beat_next;
            mstep_reg    <= mstep_next;
            m_valid_reg  <= m_valid_next;
        end
        sample_reg <= sample_next;
        mcand_reg  <= mcand_next;
        mbits_reg  <= mbits_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_div_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_st.busy || div_st.done))
        else $error("waiting on divider that is not running");

    a_beat_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && beat_reg) |-> above_reg)
        else $error("beat reported without setting the above flag");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (SUM_W + 1)'(sum_reg) <= SUM_MAX)
        else $error("window sum exceeds its maximum");

    a_div_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(div_st.busy) |-> $past(state_reg) == ST_CHECK)
        else $error("divider started outside the check step");

endmodule

@@ design/hrd_divider.sv @@
// bit-serial restoring divider: RATE_NUMERATOR / divisor, one quotient bit per cycle
// depends on hrd_pkg
module hrd_divider #(
    parameter int DIV_W = hrd_pkg::DEF_COUNT_BITS + hrd_pkg::PERIOD_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DIV_W-1:0]              divisor,
    output hrd_pkg::hrd_div_status_t      status,
    output logic [hrd_pkg::RATE_W-1:0]    quotient
);
    import hrd_pkg::*;

    localparam int STEP_W = $clog2(RATE_W);

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [RATE_W-1:0] num_reg, num_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, num_reg[RATE_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        num_next  = num_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvs_next  = divisor;
            num_next  = RATE_NUMERATOR;
            step_next = STEP_W'(RATE_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            num_next  = {num_reg[RATE_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        num_reg <= num_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = num_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg <= STEP_W'(RATE_W - 1)))
        else $error("divider step count out of range");

endmodule

@@ verif/tb_heartbeat_rate_detector.sv @@
// self-checking testbench for heartbeat_rate_detector: directed table, then random pulse trains
// every result is checked field by field, against the table for fixed rows, else against a local beat predictor
// depends on hrd_pkg and the design sources only
module tb_heartbeat_rate_detector;
    timeunit 1ns;
    timeprecision 1ps;
    import hrd_pkg::*;

    localparam int SUM_BITS       = DEF_SAMPLE_BITS + $clog2(DEF_WINDOW);
    localparam int IVL_BITS       = DEF_COUNT_BITS + PERIOD_W;
    localparam int IN_BITS        = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS       = ((1 + SUM_BITS + IVL_BITS + RATE_W + 7) / 8) * 8;
    localparam int SAMPLE_MAX     = (1 << DEF_SAMPLE_BITS) - 1;
    localparam int QUIET_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 90;
    localparam int DIRECTED_ROWS  = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    localparam int unsigned SEND_IDLE [4] = '{0, 63, 0, 36};
    localparam int unsigned RECV_STALL [4] = '{0, 0, 63, 36};

    typedef struct packed {
        logic [RATE_W-1:0]   rate;
        logic [IVL_BITS-1:0] interval;
        logic [SUM_BITS-1:0] sum;
        logic                beat;
    } beat_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] addr;
        logic [CFG_W-1:0]     value;
        logic                 fixed;
        beat_result_t         want;
    } stim_row_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr      = '0;
    logic [CFG_W-1:0]     cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_BITS-1:0]   s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [OUT_BITS-1:0]  m_axis_tdata;

    // detector copy
    logic [CFG_W-1:0]           thr_reg;
    logic [CFG_W-1:0]           period_reg;
    logic [DEF_SAMPLE_BITS-1:0] window_q [DEF_WINDOW];
    int unsigned                slot_q;
    logic [SUM_BITS-1:0]        sum_q;
    logic                       over_level;
    logic [DEF_COUNT_BITS-1:0]  since_beat;
    logic [IVL_BITS-1:0]        interval_q;
    logic [RATE_W-1:0]          rate_q;

    beat_result_t pending_results [$];
    beat_result_t got_res;
    beat_result_t want_res;
    int unsigned  errors         = 0;
    int unsigned  samples_sent   = 0;
    int unsigned  results_seen   = 0;
    int unsigned  beats_seen     = 0;
    int unsigned  quiet_cycles   = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;

    stim_row_t directed [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, '0, 10'd0,    1'b1, '{20'd0,    26'd0,  12'd0,    1'b0}},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b1, '{20'd0,    26'd0,  12'd1023, 1'b0}},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b1, '{20'd0,    26'd0,  12'd2046, 1'b0}},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b1, '{20'd7500, 26'd80, 12'd3069, 1'b1}},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b1, '{20'd7500, 26'd80, 12'd4092, 1'b0}},
        '{ROW_CFG, CFG_SPARE2, 10'd1023, 1'b0, '0},
        '{ROW_CFG, CFG_SPARE3, 10'd0,    1'b0, '0},
        // sum settles exactly on the level: no re-arm
        '{ROW_SAMPLE, '0, 10'd520,  1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd520,  1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd520,  1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd520,  1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd520,  1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd519,  1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b0, '0},
        // beat with a zero period keeps the held rate
        '{ROW_CFG, CFG_PERIOD, 10'd0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd0,    1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd0,    1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd0,    1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd0,    1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd0,    1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd0,    1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd0,    1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd0,    1'b0, '0},
        '{ROW_CFG, CFG_THRESHOLD, 10'd0, 1'b0, '0},
        '{ROW_CFG, CFG_PERIOD,    10'd1, 1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd1,    1'b0, '0},
        '{ROW_CFG, CFG_THRESHOLD, 10'd1023, 1'b0, '0},
        '{ROW_CFG, CFG_PERIOD,    10'd1000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b0, '0},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b0, '0}
    };

    heartbeat_rate_detector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // beat, average_sum, interval_ms, rate_tenths
    );

    always #1 aclk = ~aclk;

    function automatic void clear_detector();
        thr_reg    = THRESH_RESET;
        period_reg = PERIOD_RESET;
        foreach (window_q[i]) window_q[i] = '0;
        slot_q     = 0;
        sum_q      = '0;
        over_level = 1'b0;
        since_beat = '0;
        interval_q = '0;
        rate_q     = '0;
    endfunction

    function automatic beat_result_t predict_beat(input logic [DEF_SAMPLE_BITS-1:0] smp);
        beat_result_t        r;
        logic [SUM_BITS-1:0] level;
        r     = '0;
        sum_q = sum_q - SUM_BITS'(window_q[slot_q]) + SUM_BITS'(smp);
        window_q[slot_q] = smp;
        slot_q = (slot_q == DEF_WINDOW - 1) ? 0 : slot_q + 1;
        if (since_beat != '1) since_beat = since_beat + 1'b1;
        level = SUM_BITS'(DEF_WINDOW * thr_reg);
        if (!over_level && sum_q > level) begin
            over_level = 1'b1;
            r.beat     = 1'b1;
            interval_q = IVL_BITS'(since_beat) * IVL_BITS'(period_reg);
            since_beat = '0;
            if (interval_q != '0) rate_q = RATE_W'(32'(RATE_NUMERATOR) / 32'(interval_q));
        end
        if (over_level && sum_q < level) over_level = 1'b0;
        r.sum      = sum_q;
        r.interval = interval_q;
        r.rate     = rate_q;
        return r;
    endfunction

    function automatic logic [DEF_SAMPLE_BITS-1:0] level_near(input logic high_side);
        int t, lo, hi;
        t = int'(thr_reg);
        if (high_side) begin
            lo = t + 1;
            hi = t + 300;
        end else begin
            lo = t - 300;
            hi = t - 1;
        end
        if (lo < 0) lo = 0;
        if (hi < 0) hi = 0;
        if (lo > SAMPLE_MAX) lo = SAMPLE_MAX;
        if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
        return DEF_SAMPLE_BITS'($urandom_range(hi, lo));
    endfunction

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_results_done();
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_THRESHOLD) thr_reg = val;
        else if (idx == CFG_PERIOD) period_reg = val;
    endtask

    task automatic send_sample(input logic [DEF_SAMPLE_BITS-1:0] smp, input logic use_fixed,
                               input beat_result_t fixed_res);
        beat_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'(smp);
        do @(posedge aclk); while (!s_axis_tready);
        predicted = predict_beat(smp);
        pending_results.push_back(use_fixed ? fixed_res : predicted);
        samples_sent++;
        @(negedge aclk);
    endtask

    // pulses around the threshold, with bursts of full-range noise in between
    task automatic run_pulse_train(input int unsigned n_items);
        int unsigned done_items, hi_len, lo_len;
        logic        noisy;
        done_items = 0;
        while (done_items < n_items) begin
            noisy  = ($urandom_range(0, 3) == 0);
            hi_len = $urandom_range(1, 6);
            lo_len = $urandom_range(1, 12);
            repeat (hi_len)
                send_sample(noisy ? DEF_SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX))
                                  : level_near(1'b1), 1'b0, '0);
            repeat (lo_len)
                send_sample(noisy ? DEF_SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX))
                                  : level_near(1'b0), 1'b0, '0);
            done_items += hi_len + lo_len;
            if ($urandom_range(0, 15) == 0) wait_results_done();
        end
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_res = m_axis_tdata[$bits(beat_result_t)-1:0];
            results_seen++;
            if (got_res.beat) beats_seen++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending: %h", m_axis_tdata);
                errors++;
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.beat !== want_res.beat) begin
                    $error("beat: expected %0d, got %0d", want_res.beat, got_res.beat);
                    errors++;
                end
                if (got_res.sum !== want_res.sum) begin
                    $error("average_sum: expected %0d, got %0d", want_res.sum, got_res.sum);
                    errors++;
                end
                if (got_res.interval !== want_res.interval) begin
                    $error("interval_ms: expected %0d, got %0d",
                           want_res.interval, got_res.interval);
                    errors++;
                end
                if (got_res.rate !== want_res.rate) begin
                    $error("rate_tenths: expected %0d, got %0d", want_res.rate, got_res.rate);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        clear_detector();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG)
                write_register(directed[i].addr, directed[i].value);
            else
                send_sample(DEF_SAMPLE_BITS'(directed[i].value), directed[i].fixed,
                            directed[i].want);
        end

        for (int phase = 0; phase < 4; phase++) begin
            write_register(CFG_THRESHOLD, CFG_W'($urandom_range(150, 850)));
            write_register(CFG_PERIOD, phase == 0 ? 10'd1 :
                                       phase == 1 ? 10'd1000 :
                                       phase == 2 ? 10'd1023 : CFG_W'($urandom_range(2, 999)));
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            run_pulse_train(PHASE_ITEMS);
        end

        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("%0d samples, %0d results checked, %0d beats seen", samples_sent,
                 results_seen, beats_seen);
        $display("handshake mixes with idle and stall, zero to full-scale period, level ties");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ heartbeat_rate_detector.f @@
design/hrd_pkg.sv
design/hrd_divider.sv
design/heartbeat_rate_detector.sv
verif/tb_heartbeat_rate_detector.sv
